>>> src/tetc_pkg.sv
// ----------------------------------------------------------------------------
// tetc_pkg - shared definitions for the transfer encoding token classifier
// Scan phase codes, class codes, keyword tables and size constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tetc_pkg;

    // Token length limit; lengths beyond it saturate and never match
    localparam int MAX_TOKEN_BYTES = 16;
    localparam int LEN_W           = 5;
    localparam int KW_COUNT        = 5;
    localparam int KW_IDX_W        = 3;
    localparam int KW_SLOT_W       = 4;
    localparam int CLASS_W         = 3;
    localparam int PHASE_W         = 3;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_BYTES);

    // Scan phases
    localparam logic [PHASE_W-1:0] PH_LEAD       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEAD_CR    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEAD_CRLF  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TOKEN      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TRAIL      = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TRAIL_CR   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_TRAIL_CRLF = 3'd6;
    localparam logic [PHASE_W-1:0] PH_FAIL       = 3'd7;

    // Encoding classes
    localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_7BIT    = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_8BIT    = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_BINARY  = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_QP      = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_BASE64  = 3'd5;

    // Keyword indexes (class minus one)
    localparam logic [KW_IDX_W-1:0] KW_7BIT   = 3'd0;
    localparam logic [KW_IDX_W-1:0] KW_8BIT   = 3'd1;
    localparam logic [KW_IDX_W-1:0] KW_BINARY = 3'd2;
    localparam logic [KW_IDX_W-1:0] KW_QP     = 3'd3;
    localparam logic [KW_IDX_W-1:0] KW_BASE64 = 3'd4;

    // Byte codes
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Keyword length
    function automatic logic [LEN_W-1:0] kw_len(input logic [KW_IDX_W-1:0] k);
        logic [LEN_W-1:0] n;
        case (k)
            KW_7BIT:   n = 5'd4;
            KW_8BIT:   n = 5'd4;
            KW_BINARY: n = 5'd6;
            KW_QP:     n = 5'd16;
            KW_BASE64: n = 5'd6;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

    // Keyword character at a slot, lower case; zero past the end
    function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0]  k,
                                           input logic [KW_SLOT_W-1:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            KW_7BIT, KW_8BIT: begin
                case (i)
                    4'd0:    c = (k == KW_7BIT) ? "7" : "8";
                    4'd1:    c = "b";
                    4'd2:    c = "i";
                    4'd3:    c = "t";
                    default: c = 8'h00;
                endcase
            end
            KW_BINARY: begin
                case (i)
                    4'd0:    c = "b";
                    4'd1:    c = "i";
                    4'd2:    c = "n";
                    4'd3:    c = "a";
                    4'd4:    c = "r";
                    4'd5:    c = "y";
                    default: c = 8'h00;
                endcase
            end
            KW_QP: begin
                case (i)
                    4'd0:    c = "q";
                    4'd1:    c = "u";
                    4'd2:    c = "o";
                    4'd3:    c = "t";
                    4'd4:    c = "e";
                    4'd5:    c = "d";
                    4'd6:    c = "-";
                    4'd7:    c = "p";
                    4'd8:    c = "r";
                    4'd9:    c = "i";
                    4'd10:   c = "n";
                    4'd11:   c = "t";
                    4'd12:   c = "a";
                    4'd13:   c = "b";
                    4'd14:   c = "l";
                    default: c = "e";
                endcase
            end
            KW_BASE64: begin
                case (i)
                    4'd0:    c = "b";
                    4'd1:    c = "a";
                    4'd2:    c = "s";
                    4'd3:    c = "e";
                    4'd4:    c = "6";
                    4'd5:    c = "4";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> src/transfer_encoding_token_classifier.sv
// ----------------------------------------------------------------------------
// transfer_encoding_token_classifier
// Classifies a mail field value, fed one byte per item with a last mark, as a
// content transfer encoding (7bit, 8bit, binary, quoted-printable, base64 or
// unknown). The block takes one item per clock unless a last item waits for
// the result register. Each item lands in an input register, from which a
// single pass of logic updates the scan phase, token length and five keyword
// match flags; an item marked last loads the class into the result register
// once that register is free, and the result is offered from there. That
// state update, a single pass of logic, is what sets the rate. Leading and
// trailing folding whitespace is allowed; an empty value is sent as one item
// with no_byte and last_byte set. Input and result registers decouple the two
// channels, so items keep flowing while a result waits to be taken; only the
// next last item waits in the input register until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module transfer_encoding_token_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_value_byte,
    input  logic                          s_no_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tetc_pkg::CLASS_W-1:0]  m_encoding_class
);
    import tetc_pkg::*;

    // Input register
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_none_reg;
    logic                in_last_reg;

    // Scan state
    logic [PHASE_W-1:0]  phase_reg,  phase_next;
    logic [LEN_W-1:0]    len_reg,    len_next;
    logic [KW_COUNT-1:0] flags_reg,  flags_next;

    // Result register
    logic                out_valid_reg;
    logic [CLASS_W-1:0]  out_class_reg, class_next;

    logic                in_consume;
    logic                blank;
    logic [7:0]          lc_byte;
    logic                take_tok;
    logic [PHASE_W-1:0]  ph_byte;
    logic [LEN_W-1:0]    len_tok;
    logic [KW_COUNT-1:0] flags_tok;
    logic [PHASE_W-1:0]  ph_fin;
    logic [LEN_W-1:0]    len_fin;
    logic [KW_COUNT-1:0] flags_fin;

    // Handshake: only a last item waits for the result slot
    assign in_consume = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || in_consume;
    assign m_valid    = out_valid_reg;
    assign m_encoding_class = out_class_reg;

    // Byte decode
    assign blank   = (in_byte_reg == CH_SP) || (in_byte_reg == CH_HT);
    assign lc_byte = (in_byte_reg >= 8'h41 && in_byte_reg <= 8'h5A)
                     ? (in_byte_reg + 8'h20) : in_byte_reg;

    // Token byte: length step and keyword flag update
    always_comb begin
        flags_tok = flags_reg;
        len_tok   = len_reg;
        if (len_reg >= MAX_LEN) begin
            flags_tok = '0;
        end else begin
            for (int k = 0; k < KW_COUNT; k++) begin
                if (len_reg >= kw_len(KW_IDX_W'(k)) ||
                    kw_char(KW_IDX_W'(k), len_reg[KW_SLOT_W-1:0]) != lc_byte) begin
                    flags_tok[k] = 1'b0;
                end
            end
            len_tok = len_reg + LEN_W'(1);
        end
    end

    // Phase transition for one byte
    always_comb begin
        ph_byte  = phase_reg;
        take_tok = 1'b0;
        unique case (phase_reg)
            PH_LEAD: begin
                if (blank) begin
                    ph_byte = PH_LEAD;
                end else if (in_byte_reg == CH_CR) begin
                    ph_byte = PH_LEAD_CR;
                end else if (in_byte_reg == CH_LF) begin
                    ph_byte = PH_FAIL;
                end else begin
                    ph_byte  = PH_TOKEN;
                    take_tok = 1'b1;
                end
            end
            PH_LEAD_CR:   ph_byte = (in_byte_reg == CH_LF) ? PH_LEAD_CRLF : PH_FAIL;
            PH_LEAD_CRLF: ph_byte = blank ? PH_LEAD : PH_FAIL;
            PH_TOKEN: begin
                if (blank) begin
                    ph_byte = PH_TRAIL;
                end else if (in_byte_reg == CH_CR) begin
                    ph_byte = PH_TRAIL_CR;
                end else if (in_byte_reg == CH_LF) begin
                    ph_byte = PH_FAIL;
                end else begin
                    take_tok = 1'b1;
                end
            end
            PH_TRAIL: begin
                if (blank) begin
                    ph_byte = PH_TRAIL;
                end else if (in_byte_reg == CH_CR) begin
                    ph_byte = PH_TRAIL_CR;
                end else begin
                    ph_byte = PH_FAIL;
                end
            end
            PH_TRAIL_CR:   ph_byte = (in_byte_reg == CH_LF) ? PH_TRAIL_CRLF : PH_FAIL;
            PH_TRAIL_CRLF: ph_byte = blank ? PH_TRAIL : PH_FAIL;
            PH_FAIL:       ph_byte = PH_FAIL;
        endcase
    end

    // State after this item's byte (if any)
    always_comb begin
        ph_fin    = phase_reg;
        len_fin   = len_reg;
        flags_fin = flags_reg;
        if (!in_none_reg) begin
            ph_fin = ph_byte;
            if (take_tok) begin
                len_fin   = len_tok;
                flags_fin = flags_tok;
            end
        end
    end

    // Classification, first matching keyword wins
    always_comb begin
        class_next = CLS_UNKNOWN;
        if (ph_fin == PH_TOKEN || ph_fin == PH_TRAIL) begin
            priority if (flags_fin[KW_7BIT] && len_fin == kw_len(KW_7BIT)) begin
                class_next = CLS_7BIT;
            end else if (flags_fin[KW_8BIT] && len_fin == kw_len(KW_8BIT)) begin
                class_next = CLS_8BIT;
            end else if (flags_fin[KW_BINARY] && len_fin == kw_len(KW_BINARY)) begin
                class_next = CLS_BINARY;
            end else if (flags_fin[KW_QP] && len_fin == kw_len(KW_QP)) begin
                class_next = CLS_QP;
            end else if (flags_fin[KW_BASE64] && len_fin == kw_len(KW_BASE64)) begin
                class_next = CLS_BASE64;
            end else begin
                class_next = CLS_UNKNOWN;
            end
        end
    end

    // Next state: back to reset values after a last item
    always_comb begin
        if (in_last_reg) begin
            phase_next = PH_LEAD;
            len_next   = '0;
            flags_next = '1;
        end else begin
            phase_next = ph_fin;
            len_next   = len_fin;
            flags_next = flags_fin;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_value_byte;
            in_none_reg <= s_no_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            len_reg   <= '0;
            flags_reg <= '1;
        end else if (in_consume) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            flags_reg <= flags_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_consume && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (in_consume && in_last_reg) begin
            out_class_reg <= class_next;
        end
    end

    // Checks
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_consume && in_last_reg) |=> m_valid)
        else $error("last item did not produce a result");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_consume && in_last_reg) |=>
            (phase_reg == PH_LEAD && len_reg == '0 && flags_reg == '1))
        else $error("scan state not cleared after last item");

    a_len_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= MAX_LEN)
        else $error("token length past limit");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_encoding_class <= CLS_BASE64))
        else $error("encoding class out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_encoding_class)))
        else $error("stalled result changed");

endmodule

>>> tb/tb_transfer_encoding_token_classifier.sv
// ----------------------------------------------------------------------------
// tb_transfer_encoding_token_classifier - self-checking bench for the classifier
// Feeds mail field values byte by byte, then checks each class that comes out
// against a scoreboard. The scoreboard is driven by a behavioral scanner that
// follows the folding-whitespace rules and the case-insensitive keyword match.
// Both handshake sides insert random idle cycles, and once the result side
// holds off long enough to back-pressure the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_transfer_encoding_token_classifier;
    import tetc_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int ITEM_TARGET     = 550;
    localparam int HOLD_OFF_AT     = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct {
        logic [7:0]  value;
        logic        none;
        logic        last;
        int unsigned gap;
    } byte_item_t;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [7:0]          s_value_byte = 8'h00;
    logic                s_no_byte    = 1'b0;
    logic                s_last_byte  = 1'b0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [CLASS_W-1:0]  m_encoding_class;

    // Stimulus and scoreboard
    byte_item_t          pending [$];
    byte_item_t          cur;
    logic [7:0]          val_buf [$];
    logic [CLASS_W-1:0]  due_classes [$];
    int unsigned         items_total  = 0;
    int unsigned         items_taken  = 0;
    int unsigned         counted      = 0;
    int unsigned         gap_left     = 0;
    int unsigned         stall_left   = 0;
    int unsigned         rx_wait      = 0;
    int unsigned         results_seen = 0;
    int unsigned         errors       = 0;
    int unsigned         cycles       = 0;
    bit                  tx_calm      = 1'b0;
    bit                  rx_calm      = 1'b0;

    // Scanner state
    logic [PHASE_W-1:0]  scan_q   = PH_LEAD;
    logic [LEN_W-1:0]    tok_len  = '0;
    logic [KW_COUNT-1:0] kw_alive = '1;
    string               kw_word  [KW_COUNT];
    logic [CLASS_W-1:0]  kw_class [KW_COUNT];

    transfer_encoding_token_classifier DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value_byte     (s_value_byte),
        .s_no_byte        (s_no_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_encoding_class (m_encoding_class)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Behavioral scanner
    // ------------------------------------------------------------------------
    function automatic void scan_reset();
        scan_q   = PH_LEAD;
        tok_len  = '0;
        kw_alive = '1;
    endfunction

    // One token byte: lower-case it and knock out keywords that diverge
    function automatic void take_token(input logic [7:0] b);
        logic [7:0] c;
        if (tok_len >= MAX_LEN) begin
            kw_alive = '0;
            return;
        end
        c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (kw_alive[k] && (tok_len >= kw_word[k].len() || kw_word[k][tok_len] != c))
                kw_alive[k] = 1'b0;
        end
        tok_len = tok_len + 1'b1;
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        logic blank;
        blank = (b == CH_SP) || (b == CH_HT);
        case (scan_q)
            PH_LEAD: begin
                if (!blank) begin
                    if (b == CH_CR)
                        scan_q = PH_LEAD_CR;
                    else if (b == CH_LF)
                        scan_q = PH_FAIL;
                    else begin
                        take_token(b);
                        scan_q = PH_TOKEN;
                    end
                end
            end
            PH_LEAD_CR:   scan_q = (b == CH_LF) ? PH_LEAD_CRLF : PH_FAIL;
            PH_LEAD_CRLF: scan_q = blank ? PH_LEAD : PH_FAIL;
            PH_TOKEN: begin
                if (blank)
                    scan_q = PH_TRAIL;
                else if (b == CH_CR)
                    scan_q = PH_TRAIL_CR;
                else if (b == CH_LF)
                    scan_q = PH_FAIL;
                else
                    take_token(b);
            end
            PH_TRAIL: begin
                if (b == CH_CR)
                    scan_q = PH_TRAIL_CR;
                else if (!blank)
                    scan_q = PH_FAIL;
            end
            PH_TRAIL_CR:   scan_q = (b == CH_LF) ? PH_TRAIL_CRLF : PH_FAIL;
            PH_TRAIL_CRLF: scan_q = blank ? PH_TRAIL : PH_FAIL;
            default:       scan_q = PH_FAIL;
        endcase
    endfunction

    // Accepted item: advance the scanner, and on last queue the class due
    function automatic void scan_item(input logic [7:0] b, input logic none,
                                      input logic last);
        logic [CLASS_W-1:0] cls;
        if (!none)
            scan_byte(b);
        if (last) begin
            cls = CLS_UNKNOWN;
            if (scan_q == PH_TOKEN || scan_q == PH_TRAIL) begin
                for (int k = 0; k < KW_COUNT; k++) begin
                    if (cls == CLS_UNKNOWN && kw_alive[k] && tok_len == kw_word[k].len())
                        cls = kw_class[k];
                end
            end
            due_classes.push_back(cls);
            scan_reset();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    // Idle draw with occasional stretches of back-to-back traffic
    function automatic int unsigned tx_gap();
        if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
        return tx_calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic int unsigned rx_gap();
        if ($urandom_range(0, 15) == 0)
            rx_calm = !rx_calm;
        return rx_calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SP || b == CH_HT || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic void queue_item(input logic [7:0] b, input logic none,
                                       input logic last);
        byte_item_t it;
        it.value = b;
        it.none  = none;
        it.last  = last;
        it.gap   = tx_gap();
        pending.push_back(it);
        items_total++;
        if (!(none && !last))
            counted++;
    endfunction

    // Send val_buf as one value; an empty buffer or close_empty ends it with
    // a byte-less last item. Ignored byte-less items are sprinkled in on request.
    function automatic void queue_value(input bit close_empty, input bit stray_ok);
        int n;
        n = val_buf.size();
        for (int i = 0; i < n; i++) begin
            if (stray_ok && $urandom_range(0, 23) == 0)
                queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            queue_item(val_buf[i], 1'b0, (i == n - 1) && !close_empty);
        end
        if (close_empty || n == 0)
            queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        val_buf.delete();
    endfunction

    function automatic void add_fold_ws();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: val_buf.push_back(CH_SP);
                1: val_buf.push_back(CH_HT);
                default: begin
                    val_buf.push_back(CH_CR);
                    val_buf.push_back(CH_LF);
                    val_buf.push_back($urandom_range(0, 1) ? CH_SP : CH_HT);
                end
            endcase
        end
    endfunction

    // Keyword in mixed case, sometimes with one byte changed, dropped or added
    function automatic void add_keyword();
        int         k;
        int         len;
        logic [7:0] c;
        k   = $urandom_range(0, KW_COUNT - 1);
        len = kw_word[k].len();
        for (int i = 0; i < len; i++) begin
            c = kw_word[k][i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
                c = c - 8'h20;
            val_buf.push_back(c);
        end
        case ($urandom_range(0, 9))
            0: val_buf[$urandom_range(0, len - 1)] = token_byte();
            1: void'(val_buf.pop_back());
            2: val_buf.push_back(token_byte());
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] mixed_byte();
        case ($urandom_range(0, 5))
            0: return CH_SP;
            1: return CH_HT;
            2: return CH_CR;
            3: return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_directed();
        // empty value
        queue_value(1'b1, 1'b0);
        val_buf = '{"7", "b", "i", "t"};
        queue_value(1'b0, 1'b0);
        // leading fold, upper case, trailing tab
        val_buf = '{CH_CR, CH_LF, CH_SP, "8", "B", "I", "T", CH_HT};
        queue_value(1'b0, 1'b0);
        // value ends on a bare CR
        val_buf = '{CH_CR};
        queue_value(1'b0, 1'b0);
        // LF inside the token, top byte value
        val_buf = '{8'hFF, CH_LF};
        queue_value(1'b0, 1'b0);
        // second token, bottom byte value
        val_buf = '{8'h00, CH_SP, "b"};
        queue_value(1'b0, 1'b0);
        // whitespace only, a stray byte-less item, then byte-less last
        queue_item(CH_SP, 1'b0, 1'b0);
        queue_item(8'hA5, 1'b1, 1'b0);
        queue_item(8'h5A, 1'b1, 1'b1);
    endfunction

    function automatic void build_random();
        int pick;
        int n;
        while (counted < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // well-formed value around a keyword
                add_fold_ws();
                add_keyword();
                add_fold_ws();
            end else if (pick < 72) begin
                // arbitrary token, often past the length limit
                add_fold_ws();
                n = $urandom_range(1, 22);
                repeat (n) val_buf.push_back(token_byte());
                add_fold_ws();
            end else if (pick < 90) begin
                // well-formed start, then a broken fold or extra token
                add_fold_ws();
                add_keyword();
                add_fold_ws();
                case ($urandom_range(0, 4))
                    0: val_buf.push_back(CH_CR);
                    1: begin
                        val_buf.push_back(CH_CR);
                        val_buf.push_back(CH_LF);
                    end
                    2: begin
                        val_buf.push_back(CH_CR);
                        val_buf.push_back(token_byte());
                    end
                    3: val_buf.insert($urandom_range(0, val_buf.size()), CH_LF);
                    default: begin
                        val_buf.push_back($urandom_range(0, 1) ? CH_SP : CH_HT);
                        val_buf.push_back(token_byte());
                        add_fold_ws();
                    end
                endcase
            end else begin
                // noise, including whitespace-only and empty values
                n = $urandom_range(0, 12);
                repeat (n) val_buf.push_back(mixed_byte());
            end
            queue_value($urandom_range(0, 5) == 0, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
            scan_reset();
        end else begin
            if (s_valid && s_ready) begin
                scan_item(s_value_byte, s_no_byte, s_last_byte);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending.size() > 0) begin
                    cur = pending.pop_front();
                    s_value_byte <= cur.value;
                    s_no_byte    <= cur.none;
                    s_last_byte  <= cur.last;
                    s_valid      <= 1'b1;
                    gap_left     <= cur.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor with receiver stalls and one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_classes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got class %0d",
                             $time, m_encoding_class);
                    errors++;
                end else if (m_encoding_class !== due_classes[0]) begin
                    $display("%0t: encoding_class mismatch, expected %0d, got %0d",
                             $time, due_classes[0], m_encoding_class);
                    errors++;
                end
                if (due_classes.size() > 0)
                    void'(due_classes.pop_front());
                results_seen++;
                rx_wait = (results_seen == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : rx_gap();
            end else begin
                rx_wait = stall_left;
            end
            if (rx_wait > 0) begin
                m_ready    <= 1'b0;
                stall_left <= rx_wait - 1;
            end else begin
                m_ready    <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_transfer_encoding_token_classifier: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build stimulus, reset, run, drain, report
    // ------------------------------------------------------------------------
    initial begin
        kw_word  = '{"7bit", "8bit", "binary", "quoted-printable", "base64"};
        kw_class = '{CLS_7BIT, CLS_8BIT, CLS_BINARY, CLS_QP, CLS_BASE64};
        build_directed();
        build_random();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        while (items_taken < items_total) @(posedge aclk);
        while (due_classes.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && due_classes.size() == 0)
            $display("tb_transfer_encoding_token_classifier: done, clean");
        else
            $display("tb_transfer_encoding_token_classifier: done, errors");
        $finish;
    end

endmodule

>>> sim.f
src/tetc_pkg.sv
src/transfer_encoding_token_classifier.sv
tb/tb_transfer_encoding_token_classifier.sv
